/* sv/bmp24_pkg.sv */
// Shared types and constants for the 24-bit BMP framebuffer writer.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps
`default_nettype none

package bmp24_pkg;

  localparam int FB_WIDTH_DEF  = 640;
  localparam int FB_HEIGHT_DEF = 480;

  localparam int BYTE_W  = 8;
  localparam int DIM_W   = 16;
  localparam int HDR_W   = 6;
  localparam int ROW_W   = 17;
  localparam int COL_W   = 17;
  localparam int VAL_W   = 24;
  localparam int ADDR_W  = 19;
  localparam int SROW_W  = 9;
  localparam int SCOL_W  = 10;
  localparam int CFG_W   = 10;
  localparam int CIDX_W  = 1;

  localparam logic [HDR_W-1:0] HDR_LEN      = 6'd54;
  localparam logic [HDR_W-1:0] HDR_WIDTH_LO = 6'd18;
  localparam logic [HDR_W-1:0] HDR_WIDTH_HI = 6'd19;
  localparam logic [HDR_W-1:0] HDR_HGT_LO   = 6'd22;
  localparam logic [HDR_W-1:0] HDR_HGT_HI   = 6'd23;

  localparam logic [1:0] PH_BLUE  = 2'd0;
  localparam logic [1:0] PH_GREEN = 2'd1;
  localparam logic [1:0] PH_RED   = 2'd2;

  localparam logic [CIDX_W-1:0] CFG_START_ROW = 1'd0;
  localparam logic [CIDX_W-1:0] CFG_START_COL = 1'd1;

  typedef struct packed {
    logic [VAL_W-1:0] value;
    logic [ROW_W-1:0] row;
    logic [COL_W-1:0] col;
    logic             last;
  } pix_t;

endpackage

`default_nettype wire

/* sv/bmp24_parse.sv */
// Byte-stream parser: header skip, width/height capture, pixel assembly.
// Depends on bmp24_pkg; feeds one registered pixel record to bmp24_addr.
`timescale 1ns / 1ps
`default_nettype none

module bmp24_parse import bmp24_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire logic [BYTE_W-1:0] in_data_byte,
  input  wire logic              in_start_image,
  input  wire logic [SROW_W-1:0] row_base,
  input  wire logic [SCOL_W-1:0] col_base,
  output pix_t                   pix,
  output logic                   pix_valid,
  input  wire logic              pix_take
);

  logic [HDR_W-1:0] hc_r, hc_nxt;
  logic [DIM_W-1:0] wid_r, wid_nxt;
  logic [DIM_W-1:0] hgt_r, hgt_nxt;
  logic [DIM_W-1:0] frow_r, frow_nxt;
  logic [DIM_W-1:0] column_r, column_nxt;
  logic [1:0]       phase_r, phase_nxt;
  logic [1:0]       pad_r, pad_nxt;
  logic [DIM_W-1:0] bg_r, bg_nxt;
  logic             done_r, done_nxt;
  pix_t             pix_r, pix_nxt;
  logic             pv_r, pv_nxt;
  logic             acc;

  assign in_stall  = pv_r && !pix_take;
  assign acc       = in_valid && !in_stall;
  assign pix       = pix_r;
  assign pix_valid = pv_r;

  always_comb begin
    logic [HDR_W-1:0] hc;
    logic [DIM_W-1:0] wid, hgt, frow, column, bg;
    logic [1:0]       phase, pad;
    logic             done;
    logic             emit;
    logic [DIM_W-1:0] rdiff;

    hc     = hc_r;
    wid    = wid_r;
    hgt    = hgt_r;
    frow   = frow_r;
    column = column_r;
    phase  = phase_r;
    pad    = pad_r;
    bg     = bg_r;
    done   = done_r;
    if (in_start_image) begin
      hc     = '0;
      wid    = '0;
      hgt    = '0;
      frow   = '0;
      column = '0;
      phase  = PH_BLUE;
      pad    = '0;
      bg     = '0;
      done   = 1'b0;
    end

    emit          = 1'b0;
    rdiff         = hgt - DIM_W'(1) - frow;
    pix_nxt.value = {bg, in_data_byte};
    pix_nxt.row   = ROW_W'(row_base) + ROW_W'(rdiff);
    pix_nxt.col   = COL_W'(col_base) + COL_W'(column);
    pix_nxt.last  = 1'b0;

    if (!done) begin
      if (hc < HDR_LEN) begin
        unique case (hc)
          HDR_WIDTH_LO: wid[7:0]  = in_data_byte;
          HDR_WIDTH_HI: wid[15:8] = in_data_byte;
          HDR_HGT_LO:   hgt[7:0]  = in_data_byte;
          HDR_HGT_HI:   hgt[15:8] = in_data_byte;
          default: ;
        endcase
        hc = hc + HDR_W'(1);
        if (hc == HDR_LEN && (wid == '0 || hgt == '0)) begin
          done = 1'b1;
        end
      end else if (pad != 2'd0) begin
        pad = pad - 2'd1;
      end else if (phase == PH_BLUE) begin
        bg    = {in_data_byte, 8'h00};
        phase = PH_GREEN;
      end else if (phase == PH_GREEN) begin
        bg    = {bg[15:8], in_data_byte};
        phase = PH_RED;
      end else begin
        emit   = 1'b1;
        phase  = PH_BLUE;
        column = column + DIM_W'(1);
        if (column >= wid) begin
          column = '0;
          frow   = frow + DIM_W'(1);
          pad    = wid[1:0];
          if (frow >= hgt) begin
            pix_nxt.last = 1'b1;
            done         = 1'b1;
          end
        end
      end
    end

    if (acc) begin
      hc_nxt     = hc;
      wid_nxt    = wid;
      hgt_nxt    = hgt;
      frow_nxt   = frow;
      column_nxt = column;
      phase_nxt  = phase;
      pad_nxt    = pad;
      bg_nxt     = bg;
      done_nxt   = done;
    end else begin
      hc_nxt     = hc_r;
      wid_nxt    = wid_r;
      hgt_nxt    = hgt_r;
      frow_nxt   = frow_r;
      column_nxt = column_r;
      phase_nxt  = phase_r;
      pad_nxt    = pad_r;
      bg_nxt     = bg_r;
      done_nxt   = done_r;
    end

    if (acc) begin
      pv_nxt = emit;
    end else if (pix_take) begin
      pv_nxt = 1'b0;
    end else begin
      pv_nxt = pv_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hc_r     <= '0;
      wid_r    <= '0;
      hgt_r    <= '0;
      frow_r   <= '0;
      column_r <= '0;
      phase_r  <= PH_BLUE;
      pad_r    <= '0;
      bg_r     <= '0;
      done_r   <= 1'b1;
      pv_r     <= 1'b0;
    end else begin
      hc_r     <= hc_nxt;
      wid_r    <= wid_nxt;
      hgt_r    <= hgt_nxt;
      frow_r   <= frow_nxt;
      column_r <= column_nxt;
      phase_r  <= phase_nxt;
      pad_r    <= pad_nxt;
      bg_r     <= bg_nxt;
      done_r   <= done_nxt;
      pv_r     <= pv_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      pix_r <= pix_nxt;
    end
  end

endmodule

`default_nettype wire

/* sv/bmp24_addr.sv */
// Address stage: clip test, row times frame width, column add, output register.
// Depends on bmp24_pkg; takes pixel records from bmp24_parse.
`timescale 1ns / 1ps
`default_nettype none

module bmp24_addr import bmp24_pkg::*; #(
  parameter int FB_WIDTH  = FB_WIDTH_DEF,
  parameter int FB_HEIGHT = FB_HEIGHT_DEF
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire pix_t              pix,
  input  wire logic              pix_valid,
  output logic                   pix_take,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output logic [ADDR_W-1:0]      out_pixel_address,
  output logic [VAL_W-1:0]       out_pixel_value,
  output logic                   out_in_frame,
  output logic                   out_last_pixel
);

  localparam int RIDX_W = $clog2(FB_HEIGHT);
  localparam int CPOS_W = $clog2(FB_WIDTH);
  localparam int PROD_W = RIDX_W + CPOS_W + 1;
  localparam int SUM_W  = PROD_W + 1;
  localparam int WIDE_W = (SUM_W > ADDR_W) ? SUM_W : ADDR_W;

  logic              a_valid_r, a_valid_nxt;
  logic [PROD_W-1:0] a_prod_r;
  logic [CPOS_W-1:0] a_col_r;
  logic              a_inside_r;
  logic [VAL_W-1:0]  a_value_r;
  logic              a_last_r;
  logic              o_valid_r, o_valid_nxt;
  logic [ADDR_W-1:0] o_addr_r;
  logic [VAL_W-1:0]  o_value_r;
  logic              o_inside_r;
  logic              o_last_r;
  logic              load_a, load_o;
  logic              in_fb;
  logic [WIDE_W-1:0] sum;

  assign load_o   = !o_valid_r || !out_stall;
  assign load_a   = !a_valid_r || load_o;
  assign pix_take = load_a;

  assign in_fb = (pix.row < ROW_W'(FB_HEIGHT)) && (pix.col < COL_W'(FB_WIDTH));
  assign sum   = WIDE_W'(a_prod_r) + WIDE_W'(a_col_r);

  assign a_valid_nxt = load_a ? pix_valid : a_valid_r;
  assign o_valid_nxt = load_o ? a_valid_r : o_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r <= 1'b0;
      o_valid_r <= 1'b0;
    end else begin
      a_valid_r <= a_valid_nxt;
      o_valid_r <= o_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load_a) begin
      a_prod_r   <= PROD_W'(pix.row[RIDX_W-1:0]) * PROD_W'(FB_WIDTH);
      a_col_r    <= pix.col[CPOS_W-1:0];
      a_inside_r <= in_fb;
      a_value_r  <= pix.value;
      a_last_r   <= pix.last;
    end
    if (load_o) begin
      o_addr_r   <= a_inside_r ? sum[ADDR_W-1:0] : '0;
      o_value_r  <= a_value_r;
      o_inside_r <= a_inside_r;
      o_last_r   <= a_last_r;
    end
  end

  assign out_valid         = o_valid_r;
  assign out_pixel_address = o_addr_r;
  assign out_pixel_value   = o_value_r;
  assign out_in_frame      = o_inside_r;
  assign out_last_pixel    = o_last_r;

endmodule

`default_nettype wire

/* sv/bmp24_to_framebuffer_writer.sv */
// Top level of the 24-bit BMP framebuffer writer: configuration registers,
// parser and address stage. Depends on bmp24_pkg, bmp24_parse, bmp24_addr.
//
// Usage:
//   Input channel (in_valid/in_stall): one byte of a bottom-up 24-bit BMP file
//   per transfer; in_start_image marks the first byte of a file and restarts
//   parsing at any time. Bytes before the first start are ignored.
//   Output channel (out_valid/out_stall): one framebuffer write per pixel,
//   address, packed BGR value, in_frame (0 = clipped, address 0) and
//   last_pixel on the final pixel.
//   Config: cfg_we writes the row offset (index 0) or the column offset
//   (index 1); write only while the block is idle.
//   Throughput: one byte per cycle while in_stall is low; a pixel result per
//   three bytes. Path: the red byte transfer loads the pixel record register,
//   the multiply-by-width register loads from it, and the address add goes
//   into the output register that drives out_valid.
//   Reset: synchronous rst_n clears the pipeline and leaves the parser idle
//   until a start byte; offsets return to zero.
//   Stall: out_stall holds the output register; stages behind it fill, then
//   in_stall rises once the parser's pixel register is also held.
`timescale 1ns / 1ps
`default_nettype none

module bmp24_to_framebuffer_writer import bmp24_pkg::*; #(
  parameter int FB_WIDTH  = FB_WIDTH_DEF,
  parameter int FB_HEIGHT = FB_HEIGHT_DEF
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire logic [BYTE_W-1:0] in_data_byte,
  input  wire logic              in_start_image,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output logic [ADDR_W-1:0]      out_pixel_address,
  output logic [VAL_W-1:0]       out_pixel_value,
  output logic                   out_in_frame,
  output logic                   out_last_pixel,
  input  wire logic              cfg_we,
  input  wire logic [CIDX_W-1:0] cfg_index,
  input  wire logic [CFG_W-1:0]  cfg_wdata
);

  logic [SROW_W-1:0] srow_r, srow_nxt;
  logic [SCOL_W-1:0] scol_r, scol_nxt;
  pix_t              pix;
  logic              pix_valid;
  logic              pix_take;

  always_comb begin
    srow_nxt = srow_r;
    scol_nxt = scol_r;
    if (cfg_we) begin
      unique case (cfg_index)
        CFG_START_ROW: srow_nxt = cfg_wdata[SROW_W-1:0];
        CFG_START_COL: scol_nxt = cfg_wdata[SCOL_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      srow_r <= '0;
      scol_r <= '0;
    end else begin
      srow_r <= srow_nxt;
      scol_r <= scol_nxt;
    end
  end

  bmp24_parse u_parse (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_data_byte   (in_data_byte),
    .in_start_image (in_start_image),
    .row_base       (srow_r),
    .col_base       (scol_r),
    .pix            (pix),
    .pix_valid      (pix_valid),
    .pix_take       (pix_take)
  );

  bmp24_addr #(
    .FB_WIDTH  (FB_WIDTH),
    .FB_HEIGHT (FB_HEIGHT)
  ) u_addr (
    .clk               (clk),
    .rst_n             (rst_n),
    .pix               (pix),
    .pix_valid         (pix_valid),
    .pix_take          (pix_take),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_pixel_address (out_pixel_address),
    .out_pixel_value   (out_pixel_value),
    .out_in_frame      (out_in_frame),
    .out_last_pixel    (out_last_pixel)
  );

endmodule

`default_nettype wire

/* tb/sv/bmp24_fb_write_checker.sv */
// Checker for the BMP framebuffer writer: watches the byte, write and config ports,
// predicts each framebuffer write and compares it field by field.
// Depends on bmp24_pkg.
`timescale 1ns / 1ps

module bmp24_fb_write_checker import bmp24_pkg::*; #(
  parameter int FB_W = FB_WIDTH_DEF,
  parameter int FB_H = FB_HEIGHT_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic              in_stall,
  input  logic [BYTE_W-1:0] in_data_byte,
  input  logic              in_start_image,
  input  logic              out_valid,
  input  logic              out_stall,
  input  logic [ADDR_W-1:0] out_pixel_address,
  input  logic [VAL_W-1:0]  out_pixel_value,
  input  logic              out_in_frame,
  input  logic              out_last_pixel,
  input  logic              cfg_we,
  input  logic [CIDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]  cfg_wdata,
  output int                fail_count,
  output int                pending
);

  typedef struct packed {
    logic [ADDR_W-1:0] addr;
    logic [VAL_W-1:0]  value;
    logic              in_frame;
    logic              last;
  } fb_write_t;

  fb_write_t pending_writes[$];

  logic [SROW_W-1:0] row_off;
  logic [SCOL_W-1:0] col_off;
  logic [HDR_W-1:0]  hdr_cnt;
  logic [DIM_W-1:0]  img_w;
  logic [DIM_W-1:0]  img_h;
  int unsigned       src_row;
  int unsigned       src_col;
  logic [1:0]        byte_slot;
  logic [1:0]        pad_cnt;
  logic [15:0]       bg_hold;
  logic              idle;
  int                fails;

  task automatic report_mismatch(input string what, input longint got, input longint want);
    $display("%0t ns: mismatch on %s: got %0h, expected %0h", $time, what, got, want);
    fails++;
  endtask

  task automatic restart_parse();
    hdr_cnt   = '0;
    img_w     = '0;
    img_h     = '0;
    src_row   = 0;
    src_col   = 0;
    byte_slot = PH_BLUE;
    pad_cnt   = '0;
    bg_hold   = '0;
    idle      = 1'b0;
  endtask

  task automatic parse_byte(input logic [BYTE_W-1:0] b, input logic start);
    fb_write_t   wr;
    int unsigned row;
    int unsigned col;
    if (start) restart_parse();
    if (idle) return;
    if (hdr_cnt < HDR_LEN) begin
      case (hdr_cnt)
        HDR_WIDTH_LO: img_w[7:0]  = b;
        HDR_WIDTH_HI: img_w[15:8] = b;
        HDR_HGT_LO:   img_h[7:0]  = b;
        HDR_HGT_HI:   img_h[15:8] = b;
        default: ;
      endcase
      hdr_cnt++;
      if (hdr_cnt == HDR_LEN && (img_w == 0 || img_h == 0)) idle = 1'b1;
      return;
    end
    if (pad_cnt != 0) begin
      pad_cnt--;
      return;
    end
    if (byte_slot == PH_BLUE) begin
      bg_hold[15:8] = b;
      byte_slot = PH_GREEN;
      return;
    end
    if (byte_slot == PH_GREEN) begin
      bg_hold[7:0] = b;
      byte_slot = PH_RED;
      return;
    end
    // red byte completes the pixel; file rows are bottom-up
    byte_slot   = PH_BLUE;
    row         = row_off + img_h - 1 - src_row;
    col         = col_off + src_col;
    wr.value    = {bg_hold, b};
    wr.in_frame = (row < FB_H) && (col < FB_W);
    wr.addr     = wr.in_frame ? ADDR_W'(row * FB_W + col) : '0;
    wr.last     = 1'b0;
    src_col++;
    if (src_col >= img_w) begin
      src_col = 0;
      src_row++;
      pad_cnt = img_w[1:0];
      if (src_row >= img_h) begin
        wr.last = 1'b1;
        idle    = 1'b1;
      end
    end
    pending_writes.push_back(wr);
  endtask

  always @(posedge clk) begin
    fb_write_t want;
    if (!rst_n) begin
      row_off = '0;
      col_off = '0;
      restart_parse();
      idle = 1'b1;
      pending_writes.delete();
    end else begin
      if (out_valid && !out_stall) begin
        if (pending_writes.size() == 0) begin
          report_mismatch("unexpected write, address", out_pixel_address, 0);
        end else begin
          want = pending_writes.pop_front();
          if (out_pixel_address !== want.addr)
            report_mismatch("pixel_address", out_pixel_address, want.addr);
          if (out_pixel_value !== want.value)
            report_mismatch("pixel_value", out_pixel_value, want.value);
          if (out_in_frame !== want.in_frame)
            report_mismatch("in_frame", out_in_frame, want.in_frame);
          if (out_last_pixel !== want.last)
            report_mismatch("last_pixel", out_last_pixel, want.last);
        end
      end
      if (cfg_we) begin
        case (cfg_index)
          CFG_START_ROW: row_off = cfg_wdata[SROW_W-1:0];
          CFG_START_COL: col_off = cfg_wdata[SCOL_W-1:0];
          default: ;
        endcase
      end
      if (in_valid && !in_stall) parse_byte(in_data_byte, in_start_image);
    end
    pending    = pending_writes.size();
    fail_count = fails;
  end

endmodule

/* tb/sv/tb_bmp24_to_framebuffer_writer.sv */
// Testbench top for the BMP framebuffer writer: clock, reset, byte stream of
// directed and random BMP files, offset settings, receiver stalls and verdict.
// Depends on bmp24_pkg, bmp24_to_framebuffer_writer and bmp24_fb_write_checker.
`timescale 1ns / 1ps

module tb_bmp24_to_framebuffer_writer;
  import bmp24_pkg::*;

  localparam int LIMIT       = 200000;
  localparam int HOLD_CYCLES = 200;
  localparam int SETTINGS_N  = 4;
  localparam int FULL        = -1;

  typedef struct packed {
    logic [BYTE_W-1:0] data;
    logic              start;
  } bmp_byte_t;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_valid = 1'b0;
  logic              in_stall;
  logic [BYTE_W-1:0] in_data_byte = '0;
  logic              in_start_image = 1'b0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  logic [ADDR_W-1:0] out_pixel_address;
  logic [VAL_W-1:0]  out_pixel_value;
  logic              out_in_frame;
  logic              out_last_pixel;
  logic              cfg_we = 1'b0;
  logic [CIDX_W-1:0] cfg_index = CFG_START_ROW;
  logic [CFG_W-1:0]  cfg_wdata = '0;

  int        fail_count;
  int        pending;
  int        cycle_cnt = 0;
  int        hold_reqs = 0;
  int        hold_seen = 0;
  int        hold_left = 0;
  int        pix_total = 0;
  logic      no_idle = 1'b0;
  bmp_byte_t file_q[$];

  always #4 clk = ~clk;

  bmp24_to_framebuffer_writer #(
    .FB_WIDTH (FB_WIDTH_DEF),
    .FB_HEIGHT(FB_HEIGHT_DEF)
  ) u_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_data_byte     (in_data_byte),
    .in_start_image   (in_start_image),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_pixel_address(out_pixel_address),
    .out_pixel_value  (out_pixel_value),
    .out_in_frame     (out_in_frame),
    .out_last_pixel   (out_last_pixel),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata)
  );

  bmp24_fb_write_checker #(
    .FB_W(FB_WIDTH_DEF),
    .FB_H(FB_HEIGHT_DEF)
  ) u_checker (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_data_byte     (in_data_byte),
    .in_start_image   (in_start_image),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_pixel_address(out_pixel_address),
    .out_pixel_value  (out_pixel_value),
    .out_in_frame     (out_in_frame),
    .out_last_pixel   (out_last_pixel),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata),
    .fail_count       (fail_count),
    .pending          (pending)
  );

  // receiver: random stalls, plus one long hold-off on request
  always @(posedge clk) begin
    if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (hold_reqs != hold_seen) begin
      hold_seen <= hold_reqs;
      hold_left <= HOLD_CYCLES;
      out_stall <= 1'b1;
    end else begin
      out_stall <= !no_idle && ($urandom_range(99) < 12);
    end
  end

  initial begin
    while (cycle_cnt < LIMIT) begin
      @(posedge clk);
      cycle_cnt++;
    end
    $display("simulation failed");
    $finish;
  end

  function automatic logic [BYTE_W-1:0] pick_byte();
    case ($urandom_range(7))
      0:       return 8'h00;
      1:       return 8'hFF;
      default: return BYTE_W'($urandom_range(255));
    endcase
  endfunction

  function automatic void add_junk(input int n);
    for (int i = 0; i < n; i++) file_q.push_back('{data: pick_byte(), start: 1'b0});
  endfunction

  // queues one file; keep cuts it short (next start restarts the parse)
  function automatic int add_image(input int unsigned w, input int unsigned h, input int keep);
    logic [BYTE_W-1:0] b;
    int                n;
    int                pixels;
    n      = 0;
    pixels = 0;
    for (int i = 0; i < int'(HDR_LEN); i++) begin
      if (n == keep) return pixels;
      b = pick_byte();
      if (i == HDR_WIDTH_LO) b = w[7:0];
      if (i == HDR_WIDTH_HI) b = w[15:8];
      if (i == HDR_HGT_LO)   b = h[7:0];
      if (i == HDR_HGT_HI)   b = h[15:8];
      file_q.push_back('{data: b, start: (i == 0)});
      n++;
    end
    for (int unsigned r = 0; r < h; r++) begin
      for (int unsigned c = 0; c < w; c++) begin
        for (int k = 0; k < 3; k++) begin
          if (n == keep) return pixels;
          file_q.push_back('{data: pick_byte(), start: 1'b0});
          n++;
        end
        pixels++;
      end
      for (int unsigned k = 0; k < (w % 4); k++) begin
        if (n == keep) return pixels;
        file_q.push_back('{data: pick_byte(), start: 1'b0});
        n++;
      end
    end
    return pixels;
  endfunction

  function automatic int add_random_image();
    int sel;
    int pixels;
    sel = $urandom_range(99);
    if (sel < 65) begin
      pixels = add_image($urandom_range(7, 1), $urandom_range(5, 1), FULL);
      add_junk($urandom_range(3));
    end else if (sel < 75) begin
      if ($urandom_range(1))
        pixels = add_image(0, $urandom_range(65535), FULL);
      else
        pixels = add_image($urandom_range(65535), 0, FULL);
      add_junk($urandom_range(4, 1));
    end else if (sel < 85) begin
      pixels = add_image($urandom_range(65535, 1), $urandom_range(65535, 1),
                         int'(HDR_LEN) + $urandom_range(60));
    end else begin
      pixels = add_image($urandom_range(7, 1), $urandom_range(5, 1), $urandom_range(100, 1));
    end
    return pixels;
  endfunction

  task automatic send_byte(input bmp_byte_t item);
    while (!no_idle && $urandom_range(99) < 12) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid       <= 1'b1;
    in_data_byte   <= item.data;
    in_start_image <= item.start;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic set_offsets(input int unsigned row, input int unsigned col);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_START_ROW;
    cfg_wdata <= CFG_W'(row);
    @(posedge clk);
    cfg_index <= CFG_START_COL;
    cfg_wdata <= CFG_W'(col);
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic wait_drained();
    do @(posedge clk); while (pending != 0);
    repeat (6) @(posedge clk);
  endtask

  initial begin
    int unsigned row_offs[SETTINGS_N];
    int unsigned col_offs[SETTINGS_N];
    row_offs = '{0, 479, 478, 0};
    col_offs = '{0, 639, 636, 0};
    row_offs[SETTINGS_N-1] = $urandom_range(479);
    col_offs[SETTINGS_N-1] = $urandom_range(639);
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int s = 0; s < SETTINGS_N; s++) begin
      if (s > 0) wait_drained();
      set_offsets(row_offs[s], col_offs[s]);
      no_idle = (s == 1);
      if (s == 0) begin
        // idle bytes, tiny image, empty images, restarts, max-size header
        add_junk(3);
        pix_total += add_image(1, 1, FULL);
        add_junk(2);
        pix_total += add_image(0, 7, FULL);
        add_junk(2);
        pix_total += add_image(5, 0, FULL);
        pix_total += add_image(16'hFFFF, 16'hFFFF, int'(HDR_LEN) + 9);
        pix_total += add_image(3, 2, 20);
      end
      if (s == 1) pix_total += add_image(2, 2, FULL);
      if (s == 2) begin
        pix_total += add_image(4, 4, FULL);
        hold_reqs++;
      end
      while (file_q.size() < 40 || (s == SETTINGS_N - 1 && pix_total < 30))
        pix_total += add_random_image();
      while (file_q.size() > 0) send_byte(file_q.pop_front());
      in_valid <= 1'b0;
    end

    wait_drained();
    if (fail_count == 0)
      $display("simulation ok");
    else
      $display("simulation failed");
    $finish;
  end

endmodule
